@@ sv/four_register_alu_device_assert.svh @@
// Assertion macros shared by the four-register ALU device.
`ifndef FOUR_REGISTER_ALU_DEVICE_ASSERT_SVH
`define FOUR_REGISTER_ALU_DEVICE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// When the condition holds, the consequence must hold in the same cycle.
`define FRA_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("four_register_alu_device: check failed");
// When the condition holds, the consequence must hold in the next cycle.
`define FRA_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("four_register_alu_device: check failed");
`else
`define FRA_ASSERT_SAME(label, clk, rstn, cond, cons)
`define FRA_ASSERT_NEXT(label, clk, rstn, cond, cons)
`endif
`endif

@@ sv/fradev_pkg.sv @@
// Shared constants and types of the four-register ALU device.
package fradev_pkg;

    localparam int unsigned OPND_W   = 8;
    localparam int unsigned RESULT_W = 16;
    localparam int unsigned NUM_OPND = 4;
    localparam int unsigned SEL_W    = 2;

    // Request types.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_OPERATE  = 2'd1;
    localparam logic [1:0] REQ_READ_REG = 2'd2;
    localparam logic [1:0] REQ_READ_RES = 2'd3;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    // Value added to a negative raw result or taken from one above a byte.
    localparam logic [RESULT_W-1:0] ADJUST_CONST = 16'd255;

    // Command to the serial multiply and divide unit.
    typedef struct packed {
        logic start;
        logic divide;
    } mdu_cmd_t;

endpackage

@@ sv/fradev_mdu.sv @@
// Bit-serial multiply and restoring divide unit for 8-bit operands.
module fradev_mdu (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fradev_pkg::mdu_cmd_t               cmd,
    input  logic [fradev_pkg::OPND_W-1:0]      x_in,
    input  logic [fradev_pkg::OPND_W-1:0]      y_in,
    output logic                               done,
    output logic [fradev_pkg::RESULT_W-1:0]    result
);
    import fradev_pkg::*;

    localparam int unsigned CNT_W = $clog2(OPND_W);

    logic               busy_reg;
    logic               divide_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [OPND_W-1:0]  acc_reg;
    logic [OPND_W-1:0]  sh_reg;
    logic [OPND_W-1:0]  dsr_reg;
    logic               done_reg;

    logic [OPND_W:0]    mul_sum;
    logic [OPND_W+1:0]  div_trial;
    logic [OPND_W-1:0]  acc_next;
    logic [OPND_W-1:0]  sh_next;

    // One multiplier bit or one quotient bit per cycle.
    always_comb begin
        mul_sum   = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, dsr_reg} : '0);
        div_trial = {1'b0, acc_reg, sh_reg[OPND_W-1]} - {2'b00, dsr_reg};
        if (divide_reg) begin
            if (!div_trial[OPND_W+1]) begin
                acc_next = div_trial[OPND_W-1:0];
            end else begin
                acc_next = {acc_reg[OPND_W-2:0], sh_reg[OPND_W-1]};
            end
            sh_next = {sh_reg[OPND_W-2:0], ~div_trial[OPND_W+1]};
        end else begin
            acc_next = mul_sum[OPND_W:1];
            sh_next  = {mul_sum[0], sh_reg[OPND_W-1:1]};
        end
    end

    // Control: a run of OPND_W steps after each start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !cmd.start && busy_reg && (cnt_reg == CNT_W'(OPND_W - 1));
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OPND_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            divide_reg <= cmd.divide;
            acc_reg    <= '0;
            sh_reg     <= cmd.divide ? x_in : y_in;
            dsr_reg    <= cmd.divide ? y_in : x_in;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            sh_reg  <= sh_next;
        end
    end

    assign done   = done_reg;
    assign result = divide_reg ? {{(RESULT_W-OPND_W){1'b0}}, sh_reg} : {acc_reg, sh_reg};

endmodule

@@ sv/four_register_alu_device.sv @@
// Top level of the four-register ALU device.
//
// Each input word is one bus access: write an operand register (a..d), run
// add, subtract, multiply or divide on two operand registers, read an
// operand register, or read the result register with its carry flag.
// Every accepted word yields exactly one result word on the m_ channel,
// carrying read data, carry and a status bit (division by zero rejected).
// Words are processed one at a time, in order. Writes, reads, add,
// subtract and a rejected divide pass from acceptance through the execute
// and deliver states to the output register; multiply and divide also pass
// the calc state, where the bit-serial unit resolves one bit per cycle over
// the 8 operand bits. No new word is taken before the last is loaded there.
// The output register parts the two sides: a new word is accepted while a
// finished result still waits, and a stalled receiver only holds the next
// result in the delivery stage, which blocks further input.
// Synchronous active-low reset clears the operand registers, the result
// register, the carry flag and all handshake state.
`include "four_register_alu_device_assert.svh"
module four_register_alu_device (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_req_type,
    input  logic [fradev_pkg::SEL_W-1:0]     s_reg_sel,
    input  logic [fradev_pkg::OPND_W-1:0]    s_write_value,
    input  logic [fradev_pkg::SEL_W-1:0]     s_src_first,
    input  logic [fradev_pkg::SEL_W-1:0]     s_src_second,
    input  logic [1:0]                       s_opcode,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fradev_pkg::RESULT_W-1:0]  m_read_data,
    output logic                             m_carry_out,
    output logic                             m_status
);
    import fradev_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXEC    = 2'd1;
    localparam logic [1:0] ST_CALC    = 2'd2;
    localparam logic [1:0] ST_DELIVER = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OPND_W-1:0]   opnd_reg [NUM_OPND];
    logic [RESULT_W-1:0] result_reg;
    logic                carry_reg;
    logic [1:0]          req_reg;
    logic [1:0]          op_reg;
    logic [OPND_W-1:0]   x_reg;
    logic [OPND_W-1:0]   y_reg;
    logic [RESULT_W-1:0] pend_data_reg;
    logic                pend_carry_reg;
    logic                pend_status_reg;
    logic                m_valid_reg;
    logic [RESULT_W-1:0] m_data_reg;
    logic                m_carry_reg;
    logic                m_status_reg;

    logic                accept;
    logic                out_load;
    logic [SEL_W-1:0]    rd_addr_a;
    logic [OPND_W:0]     add_sum;
    logic [OPND_W:0]     sub_diff;
    logic                is_serial;
    logic                div_zero;
    mdu_cmd_t            mdu_cmd;
    logic                mdu_done;
    logic [RESULT_W-1:0] mdu_result;
    logic [RESULT_W:0]   mdu_adj;
    logic [RESULT_W:0]   add_adj;

    // Result above a byte loses 255 and sets carry; top bit is the carry.
    function automatic logic [RESULT_W:0] adjust_pos(input logic [RESULT_W-1:0] raw);
        logic [RESULT_W:0] res;
        if (raw > ADJUST_CONST) begin
            res = {1'b1, raw - ADJUST_CONST};
        end else begin
            res = {1'b0, raw};
        end
        return res;
    endfunction

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DELIVER) && (!m_valid_reg || m_ready);
    assign rd_addr_a = (s_req_type == REQ_OPERATE) ? s_src_first : s_reg_sel;

    // Narrow arithmetic is combinational; multiply and divide go serial.
    assign add_sum   = {1'b0, x_reg} + {1'b0, y_reg};
    assign sub_diff  = {1'b0, x_reg} - {1'b0, y_reg};
    assign add_adj   = adjust_pos({{(RESULT_W-OPND_W-1){1'b0}}, add_sum});
    assign mdu_adj   = adjust_pos(mdu_result);
    assign div_zero  = (op_reg == OP_DIV) && (y_reg == '0);
    assign is_serial = (req_reg == REQ_OPERATE) && !div_zero
                       && ((op_reg == OP_MUL) || (op_reg == OP_DIV));

    always_comb begin
        mdu_cmd.start  = (state_reg == ST_EXEC) && is_serial;
        mdu_cmd.divide = (op_reg == OP_DIV);
    end

    fradev_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mdu_cmd),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .done    (mdu_done),
        .result  (mdu_result)
    );

    // Sequencer for one word at a time.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = is_serial ? ST_CALC : ST_DELIVER;
            end
            ST_CALC: begin
                if (mdu_done) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Operand register file: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_OPND; i++) begin
                opnd_reg[i] <= '0;
            end
        end else if (accept && (s_req_type == REQ_WRITE)) begin
            opnd_reg[s_reg_sel] <= s_write_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= opnd_reg[rd_addr_a];
            y_reg   <= opnd_reg[s_src_second];
            req_reg <= s_req_type;
            op_reg  <= s_opcode;
        end
    end

    // Execution: update result and carry, build the pending word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            result_reg <= '0;
            carry_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC && req_reg == REQ_OPERATE) begin
                if (op_reg == OP_ADD) begin
                    result_reg <= add_adj[RESULT_W-1:0];
                    carry_reg  <= add_adj[RESULT_W];
                end else if (op_reg == OP_SUB) begin
                    result_reg <= {{(RESULT_W-OPND_W){1'b0}},
                                   sub_diff[OPND_W] ? sub_diff[OPND_W-1:0]
                                       + ADJUST_CONST[OPND_W-1:0]
                                                    : sub_diff[OPND_W-1:0]};
                    carry_reg  <= sub_diff[OPND_W];
                end
            end else if (state_reg == ST_CALC && mdu_done) begin
                result_reg <= mdu_adj[RESULT_W-1:0];
                carry_reg  <= mdu_adj[RESULT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            case (req_reg)
                REQ_READ_REG: begin
                    pend_data_reg   <= {{(RESULT_W-OPND_W){1'b0}}, x_reg};
                    pend_carry_reg  <= 1'b0;
                    pend_status_reg <= STATUS_OK;
                end
                REQ_READ_RES: begin
                    pend_data_reg   <= result_reg;
                    pend_carry_reg  <= carry_reg;
                    pend_status_reg <= STATUS_OK;
                end
                REQ_OPERATE: begin
                    pend_data_reg   <= '0;
                    pend_carry_reg  <= 1'b0;
                    pend_status_reg <= div_zero ? STATUS_DIV_ZERO : STATUS_OK;
                end
                default: begin
                    pend_data_reg   <= '0;
                    pend_carry_reg  <= 1'b0;
                    pend_status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg   <= pend_data_reg;
            m_carry_reg  <= pend_carry_reg;
            m_status_reg <= pend_status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_carry_out = m_carry_reg;
    assign m_status    = m_status_reg;

    // Checks on the sequencer and its hand-off to the output register.
    `FRA_ASSERT_NEXT(a_one_word_at_a_time, aclk, aresetn, accept, !s_ready)
    `FRA_ASSERT_SAME(a_mdu_done_in_calc, aclk, aresetn, mdu_done, state_reg == ST_CALC)
    `FRA_ASSERT_NEXT(a_load_gives_valid, aclk, aresetn, out_load, m_valid && s_ready)

endmodule

@@ test/tb_four_register_alu_device.sv @@
// Self-checking testbench for the four-register ALU device.
`timescale 1ns / 1ps

module tb_four_register_alu_device;
    import fradev_pkg::*;

    localparam int unsigned RANDOM_WORDS = 700;
    localparam int unsigned PHASE_WORDS  = 90;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned REPORT_LIMIT = 10;

    // One bus access as it is presented on the s_ channel.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [SEL_W-1:0]  reg_sel;
        logic [OPND_W-1:0] write_value;
        logic [SEL_W-1:0]  src_first;
        logic [SEL_W-1:0]  src_second;
        logic [1:0]        opcode;
    } alu_access_t;

    // One reply word as it leaves on the m_ channel.
    typedef struct packed {
        logic [RESULT_W-1:0] read_data;
        logic                carry_out;
        logic                status;
    } alu_reply_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type    = '0;
    logic [SEL_W-1:0]    s_reg_sel     = '0;
    logic [OPND_W-1:0]   s_write_value = '0;
    logic [SEL_W-1:0]    s_src_first   = '0;
    logic [SEL_W-1:0]    s_src_second  = '0;
    logic [1:0]          s_opcode      = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [RESULT_W-1:0] m_read_data;
    logic                m_carry_out;
    logic                m_status;

    // Shadow copy of the device state, advanced as words are accepted.
    logic [OPND_W-1:0]   shadow_opnd [NUM_OPND];
    logic [RESULT_W-1:0] shadow_result;
    logic                shadow_carry;

    alu_access_t pending_accesses [$];
    alu_reply_t  expected_replies [$];

    int unsigned accepted_words = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Idling percentages for each phase: none, sender, receiver, both.
    int unsigned send_gap_pct   [4] = '{0, 70, 0, 22};
    int unsigned recv_stall_pct [4] = '{0, 0, 70, 22};

    four_register_alu_device i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_reg_sel     (s_reg_sel),
        .s_write_value (s_write_value),
        .s_src_first   (s_src_first),
        .s_src_second  (s_src_second),
        .s_opcode      (s_opcode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_carry_out   (m_carry_out),
        .m_status      (m_status)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one access to the shadow state and returns the reply it causes.
    function automatic alu_reply_t predict_reply(alu_access_t acc);
        alu_reply_t        reply;
        logic [OPND_W-1:0] lhs;
        logic [OPND_W-1:0] rhs;
        int                raw;
        reply = '0;
        reply.status = STATUS_OK;
        case (acc.req_type)
            REQ_WRITE: begin
                shadow_opnd[acc.reg_sel] = acc.write_value;
            end
            REQ_OPERATE: begin
                lhs = shadow_opnd[acc.src_first];
                rhs = shadow_opnd[acc.src_second];
                case (acc.opcode)
                    OP_ADD:  raw = int'(lhs) + int'(rhs);
                    OP_SUB:  raw = int'(lhs) - int'(rhs);
                    OP_MUL:  raw = int'(lhs) * int'(rhs);
                    default: raw = (rhs == '0) ? 0 : int'(lhs / rhs);
                endcase
                if (acc.opcode == OP_DIV && rhs == '0) begin
                    // A divide by zero leaves the result and carry alone.
                    reply.status = STATUS_DIV_ZERO;
                end else begin
                    if (raw < 0) begin
                        raw += int'(ADJUST_CONST);
                        shadow_carry = 1'b1;
                    end else if (raw > 255) begin
                        raw -= int'(ADJUST_CONST);
                        shadow_carry = 1'b1;
                    end else begin
                        shadow_carry = 1'b0;
                    end
                    shadow_result = raw[RESULT_W-1:0];
                end
            end
            REQ_READ_REG: begin
                reply.read_data = RESULT_W'(shadow_opnd[acc.reg_sel]);
            end
            default: begin
                reply.read_data = shadow_result;
                reply.carry_out = shadow_carry;
            end
        endcase
        return reply;
    endfunction

    // Queues one access; fields the access does not use get random values.
    task automatic queue_access(logic [1:0] req, int unsigned sel,
                                int unsigned wval, int unsigned first,
                                int unsigned second, logic [1:0] op);
        alu_access_t acc;
        acc.req_type    = req;
        acc.reg_sel     = SEL_W'((req == REQ_WRITE || req == REQ_READ_REG) ? sel
                                                                      : $urandom_range(3));
        acc.write_value = OPND_W'((req == REQ_WRITE) ? wval : $urandom_range(255));
        acc.src_first   = SEL_W'((req == REQ_OPERATE) ? first : $urandom_range(3));
        acc.src_second  = SEL_W'((req == REQ_OPERATE) ? second : $urandom_range(3));
        acc.opcode      = (req == REQ_OPERATE) ? op : 2'($urandom_range(3));
        pending_accesses.push_back(acc);
    endtask

    // Driver: presents pending words and predicts each one as it is accepted.
    always @(posedge aclk) begin : word_driver
        logic        holding;
        int unsigned phase;
        holding = s_valid;
        phase   = (accepted_words / PHASE_WORDS) % 4;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_replies.push_back(predict_reply(pending_accesses.pop_front()));
                accepted_words++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_accesses.size() != 0 &&
                    $urandom_range(99) >= send_gap_pct[phase]) begin
                    s_valid       <= 1'b1;
                    s_req_type    <= pending_accesses[0].req_type;
                    s_reg_sel     <= pending_accesses[0].reg_sel;
                    s_write_value <= pending_accesses[0].write_value;
                    s_src_first   <= pending_accesses[0].src_first;
                    s_src_second  <= pending_accesses[0].src_second;
                    s_opcode      <= pending_accesses[0].opcode;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every reply word with the oldest expectation.
    always @(posedge aclk) begin : reply_monitor
        alu_reply_t  want;
        int unsigned phase;
        phase = (accepted_words / PHASE_WORDS) % 4;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected reply: data %0d carry %0b status %0b",
                                 m_read_data, m_carry_out, m_status);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_read_data !== want.read_data || m_carry_out !== want.carry_out ||
                        m_status !== want.status) begin
                        mismatch_count++;
                        // Values are given as data/carry/status.
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     want.read_data, want.carry_out, want.status,
                                     m_read_data, m_carry_out, m_status);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct[phase]);
        end
    end

    // Watchdog on the length of the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int unsigned roll;
        logic [1:0]  req;
        int unsigned wval;
        logic        after_op;
        for (int i = 0; i < NUM_OPND; i++)
            shadow_opnd[i] = '0;
        shadow_result = '0;
        shadow_carry  = 1'b0;

        // Directed words: the result straight after reset, extreme operands,
        // carries in both directions, the boundary at 256 and division by zero.
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_WRITE, 0, 255, 0, 0, OP_ADD);
        queue_access(REQ_WRITE, 1, 0, 0, 0, OP_ADD);
        queue_access(REQ_WRITE, 2, 1, 0, 0, OP_ADD);
        queue_access(REQ_WRITE, 3, 128, 0, 0, OP_ADD);
        for (int unsigned i = 0; i < NUM_OPND; i++)
            queue_access(REQ_READ_REG, i, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 1, 0, OP_SUB);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 0, 0, OP_MUL);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 0, 1, OP_DIV);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 0, 2, OP_DIV);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 1, 1, OP_ADD);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 3, 2, OP_SUB);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);
        queue_access(REQ_OPERATE, 0, 0, 0, 2, OP_ADD);
        queue_access(REQ_READ_RES, 0, 0, 0, 0, OP_ADD);

        // Random words; an operation is usually followed by a result read.
        after_op = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (after_op && $urandom_range(99) < 60) begin
                req = REQ_READ_RES;
            end else begin
                roll = $urandom_range(99);
                if (roll < 30)
                    req = REQ_WRITE;
                else if (roll < 60)
                    req = REQ_OPERATE;
                else if (roll < 75)
                    req = REQ_READ_REG;
                else
                    req = REQ_READ_RES;
            end
            roll = $urandom_range(7);
            if (roll == 0)
                wval = 0;
            else if (roll == 1)
                wval = 255;
            else
                wval = $urandom_range(255);
            queue_access(req, $urandom_range(3), wval, $urandom_range(3),
                         $urandom_range(3), 2'($urandom_range(3)));
            after_op = (req == REQ_OPERATE);
        end

        // Hold synchronous reset, then release it.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to be taken and every reply to come back.
        while (pending_accesses.size() != 0 || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/fradev_pkg.sv
sv/fradev_mdu.sv
sv/four_register_alu_device.sv
test/tb_four_register_alu_device.sv
